/* rtl/core/fxa_pkg.sv */
// fixed_point_alu package: opcodes, status codes and the pipeline carry type
// no dependencies
`default_nettype none
package fxa_pkg;
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_GT  = 4'd4;
  localparam logic [3:0] OP_LT  = 4'd5;
  localparam logic [3:0] OP_GE  = 4'd6;
  localparam logic [3:0] OP_LE  = 4'd7;
  localparam logic [3:0] OP_EQ  = 4'd8;
  localparam logic [3:0] OP_NE  = 4'd9;
  localparam logic [3:0] OP_MIN = 4'd10;
  localparam logic [3:0] OP_MAX = 4'd11;
  localparam logic [3:0] OP_INC = 4'd12;
  localparam logic [3:0] OP_DEC = 4'd13;
  localparam logic [3:0] OP_FROM_INT = 4'd14;
  localparam logic [3:0] OP_TO_INT   = 4'd15;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam int NUM_BITS = 64;  // width of dividend magnitude register
  localparam int DEN_BITS = 34;  // twice the divisor magnitude, up to 2^32

  // per-stage divider carry
  typedef struct packed {
    logic                valid;
    logic                neg;
    logic [NUM_BITS-1:0] num;   // remaining dividend bits, shifted left
    logic [DEN_BITS:0]   rem;   // partial remainder
    logic [DEN_BITS-1:0] den;
    logic [NUM_BITS-1:0] quo;
  } div_cell_t;

  // side result carried alongside the divider
  typedef struct packed {
    logic        use_div;
    logic        div0;
    logic [31:0] result;
    logic        cmp;
    logic [1:0]  status;
  } side_t;
endpackage
`default_nettype wire

/* rtl/core/fixed_point_alu.sv */
// fixed_point_alu top level: operand decode, multiplier, divider cell chain,
// saturation and result register; depends on fxa_pkg and fxa_div_cell
//
// a new request transfers on any cycle that start is high; busy is never
// raised, so one request a cycle is sustained. every request gives exactly
// one result strobe (done), after the stage 1 register, the divider chain
// of one cell per quotient bit and the output register. all opcodes travel
// the same chain so results keep order. the receiver cannot hold results
// off: each result stands for one cycle.
`default_nettype none
module fixed_point_alu #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         req_type,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic                    done,
  output logic signed [31:0]      result,
  output logic                    compare_true,
  output logic [1:0]              status
);
  localparam int EFF_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int CELLS = fxa_pkg::NUM_BITS;
  localparam logic signed [65:0] WMAX = (66'sd1 <<< (EFF_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] WMIN = -WMAX - 66'sd1;

  assign busy = 1'b0;

  // stage 1: register the request and the raw product
  logic              s1_valid;
  logic [3:0]        s1_op;
  logic signed [31:0] s1_a, s1_b;
  logic signed [63:0] s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
    s1_op   <= req_type;
    s1_a    <= operand_a;
    s1_b    <= operand_b;
    s1_prod <= 64'(operand_a) * 64'(operand_b);
  end

  // saturating clamp of a wide signed value
  function automatic logic [32:0] clamp(input logic signed [65:0] v);
    if (v > WMAX) return {1'b1, WMAX[31:0]};
    if (v < WMIN) return {1'b1, WMIN[31:0]};
    return {1'b0, v[31:0]};
  endfunction

  // stage 1 decode: every opcode but the divide finishes here
  fxa_pkg::side_t     side0;
  fxa_pkg::div_cell_t cell0;
  logic signed [65:0] wa, wb, wv;
  logic [63:0] pm;
  logic [64:0] pq;
  logic [32:0] cl;
  logic [31:0] amag, bmag;

  always_comb begin
    wa = 66'(s1_a);
    wb = 66'(s1_b);
    wv = '0;
    pm = s1_prod[63] ? (64'd0 - s1_prod) : s1_prod;
    pq = ({1'b0, pm} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    side0 = '0;
    side0.status = fxa_pkg::ST_OK;
    unique case (s1_op)
      fxa_pkg::OP_ADD: wv = wa + wb;
      fxa_pkg::OP_SUB: wv = wa - wb;
      fxa_pkg::OP_MUL: wv = s1_prod[63] ? -66'(pq) : 66'(pq);
      fxa_pkg::OP_DIV: wv = '0;
      fxa_pkg::OP_GT:  side0.cmp = s1_a > s1_b;
      fxa_pkg::OP_LT:  side0.cmp = s1_a < s1_b;
      fxa_pkg::OP_GE:  side0.cmp = s1_a >= s1_b;
      fxa_pkg::OP_LE:  side0.cmp = s1_a <= s1_b;
      fxa_pkg::OP_EQ:  side0.cmp = s1_a == s1_b;
      fxa_pkg::OP_NE:  side0.cmp = s1_a != s1_b;
      fxa_pkg::OP_MIN: wv = (wa <= wb) ? wa : wb;
      fxa_pkg::OP_MAX: wv = (wa >= wb) ? wa : wb;
      fxa_pkg::OP_INC: wv = wa + 66'sd1;
      fxa_pkg::OP_DEC: wv = wa - 66'sd1;
      fxa_pkg::OP_FROM_INT: wv = wa <<< FRAC_BITS;
      fxa_pkg::OP_TO_INT:   wv = wa >>> FRAC_BITS;
      default: wv = '0;
    endcase
    cl = clamp(wv);
    // to_int is never clamped, whatever the word width
    side0.result = (s1_op == fxa_pkg::OP_TO_INT) ? wv[31:0] : cl[31:0];
    if (cl[32] && s1_op != fxa_pkg::OP_TO_INT) side0.status = fxa_pkg::ST_SAT;
    side0.use_div = (s1_op == fxa_pkg::OP_DIV);
    side0.div0 = side0.use_div && (s1_b == 32'sd0);
    if (side0.div0) side0.status = fxa_pkg::ST_DIV0;

    // divider: (2*|a|<<F + |b|) / (2*|b|)
    amag = s1_a[31] ? (32'd0 - s1_a) : s1_a;
    bmag = s1_b[31] ? (32'd0 - s1_b) : s1_b;
    cell0.valid = s1_valid;
    cell0.neg   = s1_a[31] ^ s1_b[31];
    cell0.num   = (64'(amag) << (FRAC_BITS + 1)) + 64'(bmag);
    cell0.rem   = '0;
    cell0.den   = {1'b0, bmag, 1'b0};
    cell0.quo   = '0;
  end

  fxa_pkg::div_cell_t chain [CELLS+1];
  fxa_pkg::side_t     sides [CELLS+1];
  assign chain[0] = cell0;
  assign sides[0] = side0;

  // one restoring cell per quotient bit
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    fxa_div_cell u_cell (
      .clk (clk), .rst (rst),
      .cin (chain[g]), .sin (sides[g]),
      .cout(chain[g+1]), .sout(sides[g+1])
    );
  end

  // final saturation of the quotient and output register
  fxa_pkg::div_cell_t fin;
  fxa_pkg::side_t     fside;
  logic signed [65:0] qv;
  logic [32:0]        qc;

  always_comb begin
    fin   = chain[CELLS];
    fside = sides[CELLS];
    qv = fin.neg ? -66'(fin.quo) : 66'(fin.quo);
    qc = clamp(qv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
    compare_true <= fside.cmp;
    if (fside.use_div && !fside.div0) begin
      result <= qc[31:0];
      status <= qc[32] ? fxa_pkg::ST_SAT : fxa_pkg::ST_OK;
    end else begin
      result <= fside.result;
      status <= fside.status;
    end
  end

  // a strobed result never carries a status code beyond the defined ones
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("bad status code");
  // comparisons give no raw result and never saturate
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    done && compare_true |-> result == 32'sd0 && status == fxa_pkg::ST_OK)
    else $error("comparison carried a result");
  // division by zero gives zero
  a_div0: assert property (@(posedge clk) disable iff (rst)
    done && status == fxa_pkg::ST_DIV0 |-> result == 32'sd0)
    else $error("division by zero gave a value");
endmodule
`default_nettype wire

/* rtl/core/fxa_div_cell.sv */
// fixed_point_alu divider cell: one restoring quotient bit per cycle
// depends on fxa_pkg
`default_nettype none
module fxa_div_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fxa_pkg::div_cell_t cin,
  input  wire fxa_pkg::side_t     sin,
  output fxa_pkg::div_cell_t      cout,
  output fxa_pkg::side_t          sout
);
  fxa_pkg::div_cell_t nxt;
  logic [fxa_pkg::DEN_BITS:0] trial;
  logic [fxa_pkg::DEN_BITS+1:0] diff;

  always_comb begin
    trial = {cin.rem[fxa_pkg::DEN_BITS-1:0], cin.num[fxa_pkg::NUM_BITS-1]};
    diff  = {1'b0, trial} - {2'b00, cin.den};
    nxt = cin;
    nxt.num = {cin.num[fxa_pkg::NUM_BITS-2:0], 1'b0};
    if (!diff[fxa_pkg::DEN_BITS+1]) begin
      nxt.rem = diff[fxa_pkg::DEN_BITS:0];
      nxt.quo = {cin.quo[fxa_pkg::NUM_BITS-2:0], 1'b1};
    end else begin
      nxt.rem = trial;
      nxt.quo = {cin.quo[fxa_pkg::NUM_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else begin
      cout.valid <= cin.valid;
    end
    cout.neg <= nxt.neg;
    cout.num <= nxt.num;
    cout.rem <= nxt.rem;
    cout.den <= nxt.den;
    cout.quo <= nxt.quo;
    sout     <= sin;
  end
endmodule
`default_nettype wire
